/* src/ashit_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ashit_pkg
// Shared types, constants and the arctangent table of the annular sector
// hit test.
// ----------------------------------------------------------------------------
package ashit_pkg;

   // default geometry
   localparam int COORD_BITS_DEFAULT = 10;
   localparam int ANGLE_BITS_DEFAULT = 16;

   // register indexes of the csr port
   typedef enum logic [0:0] {
      CSR_CENTRE_X = 1'b0,
      CSR_CENTRE_Y = 1'b1
   } ashit_csr_type;

   // per-item flags that ride along the cordic chain
   typedef struct packed {
      logic band;
      logic centre;
      logic sweep_zero;
      logic sweep_full;
   } ashit_flags_type;

   // atan(2^-i) as a fraction of a full turn, scaled by 2^32
   localparam int ATAN_ENTRIES = 24;
   localparam logic [31:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   // table angle rounded to nearest at the given angle width
   function automatic logic [31:0] atan_angle(input int idx, input int abits);
      logic [32:0] sum;
      sum = {1'b0, ATAN_TURN32[idx]} + (33'd1 << (31 - abits));
      return 32'(sum >> (32 - abits));
   endfunction

endpackage

/* src/ashit_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ashit_front
// Three-stage front end: centre offset, exact squared distance band test,
// and setup of the cordic vector (left half plane folded by half a turn).
// ----------------------------------------------------------------------------
module ashit_front #(
   parameter int COORD_BITS = ashit_pkg::COORD_BITS_DEFAULT,
   parameter int ANGLE_BITS = ashit_pkg::ANGLE_BITS_DEFAULT,
   parameter int LANE_BITS  = COORD_BITS + ANGLE_BITS + 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [COORD_BITS-1:0]         centre_x,
   input  logic [COORD_BITS-1:0]         centre_y,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [COORD_BITS-1:0]         point_x,
   input  logic [COORD_BITS-1:0]         point_y,
   input  logic [COORD_BITS-1:0]         inner_radius,
   input  logic [COORD_BITS-1:0]         outer_radius,
   input  logic [ANGLE_BITS-1:0]         start_angle,
   input  logic [ANGLE_BITS:0]           sweep_angle,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [LANE_BITS-1:0]   out_x,
   output logic signed [LANE_BITS-1:0]   out_y,
   output logic [ANGLE_BITS-1:0]         out_z,
   output logic [ANGLE_BITS-1:0]         out_start,
   output logic [ANGLE_BITS-1:0]         out_sweep,
   output ashit_pkg::ashit_flags_type    out_flags
);
   import ashit_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int SW = 2 * COORD_BITS;

   // stage valid flags and flow control
   logic a_valid_ff, a_valid_in, a_ready, a_load;
   logic b_valid_ff, b_valid_in, b_ready, b_load;
   logic c_valid_ff, c_valid_in, c_ready, c_load;

   assign c_ready  = !c_valid_ff || out_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   assign a_load = in_valid && a_ready;
   assign b_load = a_valid_ff && b_ready;
   assign c_load = b_valid_ff && c_ready;

   assign a_valid_in = a_load || (a_valid_ff && !b_ready);
   assign b_valid_in = b_load || (b_valid_ff && !c_ready);
   assign c_valid_in = c_load || (c_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   // stage a: offset from centre
   logic signed [DW-1:0]   dx_a_ff, dy_a_ff, dx_a_in, dy_a_in;
   logic [COORD_BITS-1:0]  r0_a_ff, r1_a_ff;
   logic [ANGLE_BITS-1:0]  start_a_ff;
   logic [ANGLE_BITS:0]    sweep_a_ff;

   assign dx_a_in = $signed({1'b0, point_x}) - $signed({1'b0, centre_x});
   assign dy_a_in = $signed({1'b0, point_y}) - $signed({1'b0, centre_y});

   always_ff @(posedge clock) begin
      if (a_load) begin
         dx_a_ff    <= dx_a_in;
         dy_a_ff    <= dy_a_in;
         r0_a_ff    <= inner_radius;
         r1_a_ff    <= outer_radius;
         start_a_ff <= start_angle;
         sweep_a_ff <= sweep_angle;
      end
   end

   // stage b: squares
   logic signed [2*DW-1:0] prod_x, prod_y;
   logic [SW-1:0]          sqx_b_ff, sqy_b_ff, r0sq_b_ff, r1sq_b_ff;
   logic [SW-1:0]          r0sq_b_in, r1sq_b_in;
   logic signed [DW-1:0]   dx_b_ff, dy_b_ff;
   logic [ANGLE_BITS-1:0]  start_b_ff;
   logic [ANGLE_BITS:0]    sweep_b_ff;

   assign prod_x    = dx_a_ff * dx_a_ff;
   assign prod_y    = dy_a_ff * dy_a_ff;
   assign r0sq_b_in = r0_a_ff * r0_a_ff;
   assign r1sq_b_in = r1_a_ff * r1_a_ff;

   always_ff @(posedge clock) begin
      if (b_load) begin
         sqx_b_ff   <= prod_x[SW-1:0];
         sqy_b_ff   <= prod_y[SW-1:0];
         r0sq_b_ff  <= r0sq_b_in;
         r1sq_b_ff  <= r1sq_b_in;
         dx_b_ff    <= dx_a_ff;
         dy_b_ff    <= dy_a_ff;
         start_b_ff <= start_a_ff;
         sweep_b_ff <= sweep_a_ff;
      end
   end

   // stage c: band compare and cordic vector setup
   logic [SW:0]                  dist_sq;
   logic signed [LANE_BITS-1:0]  dx_w, dy_w;
   logic                         fold;
   logic signed [LANE_BITS-1:0]  x_c_in, y_c_in;
   logic [ANGLE_BITS-1:0]        z_c_in;
   ashit_flags_type              flags_c_in;
   logic signed [LANE_BITS-1:0]  x_c_ff, y_c_ff;
   logic [ANGLE_BITS-1:0]        z_c_ff, start_c_ff, sweep_c_ff;
   ashit_flags_type              flags_c_ff;

   assign dist_sq = {1'b0, sqx_b_ff} + {1'b0, sqy_b_ff};
   assign dx_w    = {{(LANE_BITS-DW){dx_b_ff[DW-1]}}, dx_b_ff};
   assign dy_w    = {{(LANE_BITS-DW){dy_b_ff[DW-1]}}, dy_b_ff};
   // x starts as -dy; a negative x folds the vector by half a turn
   assign fold    = !dy_b_ff[DW-1] && (dy_b_ff != '0);

   always_comb begin
      if (fold) begin
         x_c_in = dy_w <<< ANGLE_BITS;
         y_c_in = (-dx_w) <<< ANGLE_BITS;
         z_c_in = {1'b1, {(ANGLE_BITS-1){1'b0}}};
      end else begin
         x_c_in = (-dy_w) <<< ANGLE_BITS;
         y_c_in = dx_w <<< ANGLE_BITS;
         z_c_in = '0;
      end
      flags_c_in.band       = !((dist_sq < {1'b0, r0sq_b_ff}) ||
                                (dist_sq > {1'b0, r1sq_b_ff}));
      flags_c_in.centre     = (dx_b_ff == '0) && (dy_b_ff == '0);
      flags_c_in.sweep_zero = (sweep_b_ff == '0);
      flags_c_in.sweep_full = sweep_b_ff[ANGLE_BITS];
   end

   always_ff @(posedge clock) begin
      if (c_load) begin
         x_c_ff     <= x_c_in;
         y_c_ff     <= y_c_in;
         z_c_ff     <= z_c_in;
         flags_c_ff <= flags_c_in;
         start_c_ff <= start_b_ff;
         sweep_c_ff <= sweep_b_ff[ANGLE_BITS-1:0];
      end
   end

   assign out_valid = c_valid_ff;
   assign out_x     = x_c_ff;
   assign out_y     = y_c_ff;
   assign out_z     = z_c_ff;
   assign out_start = start_c_ff;
   assign out_sweep = sweep_c_ff;
   assign out_flags = flags_c_ff;

endmodule

/* src/ashit_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ashit_cell
// One cordic vectoring iteration with its own pipeline register; the wedge
// data and flags ride along unchanged.
// ----------------------------------------------------------------------------
module ashit_cell #(
   parameter int ANGLE_BITS = ashit_pkg::ANGLE_BITS_DEFAULT,
   parameter int LANE_BITS  = ashit_pkg::COORD_BITS_DEFAULT + ANGLE_BITS + 3,
   parameter int STAGE      = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [LANE_BITS-1:0]   in_x,
   input  logic signed [LANE_BITS-1:0]   in_y,
   input  logic [ANGLE_BITS-1:0]         in_z,
   input  logic [ANGLE_BITS-1:0]         in_start,
   input  logic [ANGLE_BITS-1:0]         in_sweep,
   input  ashit_pkg::ashit_flags_type    in_flags,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [LANE_BITS-1:0]   out_x,
   output logic signed [LANE_BITS-1:0]   out_y,
   output logic [ANGLE_BITS-1:0]         out_z,
   output logic [ANGLE_BITS-1:0]         out_start,
   output logic [ANGLE_BITS-1:0]         out_sweep,
   output ashit_pkg::ashit_flags_type    out_flags
);
   import ashit_pkg::*;

   localparam logic [31:0] ANGLE_WIDE = atan_angle(STAGE, ANGLE_BITS);
   localparam logic [ANGLE_BITS-1:0] ANGLE = ANGLE_WIDE[ANGLE_BITS-1:0];

   logic valid_ff, valid_in, load;
   logic signed [LANE_BITS-1:0] xs, ys, x_in, y_in, x_ff, y_ff;
   logic [ANGLE_BITS-1:0] z_in, z_ff, start_ff, sweep_ff;
   ashit_flags_type flags_ff;

   // flow control
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // rotate toward the x axis, arithmetic shifts round toward minus infinity
   assign xs = in_x >>> STAGE;
   assign ys = in_y >>> STAGE;

   always_comb begin
      priority if (!in_y[LANE_BITS-1] && (in_y != '0)) begin
         x_in = in_x + ys;
         y_in = in_y - xs;
         z_in = in_z + ANGLE;
      end else if (in_y[LANE_BITS-1]) begin
         x_in = in_x - ys;
         y_in = in_y + xs;
         z_in = in_z - ANGLE;
      end else begin
         x_in = in_x;
         y_in = in_y;
         z_in = in_z;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         z_ff     <= z_in;
         start_ff <= in_start;
         sweep_ff <= in_sweep;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_start = start_ff;
   assign out_sweep = sweep_ff;
   assign out_flags = flags_ff;

endmodule

/* src/ashit_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ashit_back
// Wedge test on the final bearing and the result output register.
// ----------------------------------------------------------------------------
module ashit_back #(
   parameter int ANGLE_BITS = ashit_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [ANGLE_BITS-1:0]         in_z,
   input  logic [ANGLE_BITS-1:0]         in_start,
   input  logic [ANGLE_BITS-1:0]         in_sweep,
   input  ashit_pkg::ashit_flags_type    in_flags,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic                          out_hit,
   output logic                          out_in_band,
   output logic [ANGLE_BITS-1:0]         out_bearing
);
   import ashit_pkg::*;

   localparam logic [ANGLE_BITS-1:0] HALF_TURN = {1'b1, {(ANGLE_BITS-1){1'b0}}};

   logic valid_ff, valid_in, load;
   logic [ANGLE_BITS-1:0] bearing_in, offset, bearing_ff;
   logic hit_in, hit_ff, band_ff;

   // flow control
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // a point at the centre reads half a turn
   assign bearing_in = in_flags.centre ? HALF_TURN : in_z;
   // clockwise offset from the wedge start, wraps at a full turn
   assign offset     = bearing_in - in_start;
   assign hit_in     = in_flags.band && !in_flags.sweep_zero &&
                       (in_flags.sweep_full || (offset < in_sweep));

   always_ff @(posedge clock) begin
      if (load) begin
         bearing_ff <= bearing_in;
         hit_ff     <= hit_in;
         band_ff    <= in_flags.band;
      end
   end

   assign out_valid   = valid_ff;
   assign out_hit     = hit_ff;
   assign out_in_band = band_ff;
   assign out_bearing = bearing_ff;

endmodule

/* src/annular_sector_hit_test.sv */
`timescale 1ns / 1ps
// Stages: three in the front end, one cordic cell per angle bit, one output register.
// Throughput: one item per cycle while the result side does not stall; each cell
// holds one iteration and passes its item on.
// Stalls on the result side fill empty stages first, so requests keep flowing.
// Reset: synchronous, clears all stage valid flags and both centre registers to 0.
// ----------------------------------------------------------------------------
// annular_sector_hit_test
// Tests a screen point against an annular wedge of a round display, with the
// bearing found by a pipelined chain of cordic vectoring cells.
// ----------------------------------------------------------------------------
module annular_sector_hit_test #(
   parameter int COORD_BITS = ashit_pkg::COORD_BITS_DEFAULT,
   parameter int ANGLE_BITS = ashit_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [0:0]             csr_index,
   input  logic [COORD_BITS-1:0]  csr_wr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [COORD_BITS-1:0]  req_point_x,
   input  logic [COORD_BITS-1:0]  req_point_y,
   input  logic [COORD_BITS-1:0]  req_inner_radius,
   input  logic [COORD_BITS-1:0]  req_outer_radius,
   input  logic [ANGLE_BITS-1:0]  req_start_angle,
   input  logic [ANGLE_BITS:0]    req_sweep_angle,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_hit,
   output logic                   rsp_in_band,
   output logic [ANGLE_BITS-1:0]  rsp_bearing
);
   import ashit_pkg::*;

   localparam int LANE_BITS = COORD_BITS + ANGLE_BITS + 3;

   // centre registers
   logic [COORD_BITS-1:0] centre_x_ff, centre_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_x_ff <= '0;
         centre_y_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (ashit_csr_type'(csr_index))
            CSR_CENTRE_X: centre_x_ff <= csr_wr_data;
            CSR_CENTRE_Y: centre_y_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // links between front end, cells and back end
   logic                         link_valid [ANGLE_BITS+1];
   logic                         link_ready [ANGLE_BITS+1];
   logic signed [LANE_BITS-1:0]  link_x     [ANGLE_BITS+1];
   logic signed [LANE_BITS-1:0]  link_y     [ANGLE_BITS+1];
   logic [ANGLE_BITS-1:0]        link_z     [ANGLE_BITS+1];
   logic [ANGLE_BITS-1:0]        link_start [ANGLE_BITS+1];
   logic [ANGLE_BITS-1:0]        link_sweep [ANGLE_BITS+1];
   ashit_flags_type              link_flags [ANGLE_BITS+1];

   ashit_front #(
      .COORD_BITS (COORD_BITS),
      .ANGLE_BITS (ANGLE_BITS),
      .LANE_BITS  (LANE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .centre_x     (centre_x_ff),
      .centre_y     (centre_y_ff),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .point_x      (req_point_x),
      .point_y      (req_point_y),
      .inner_radius (req_inner_radius),
      .outer_radius (req_outer_radius),
      .start_angle  (req_start_angle),
      .sweep_angle  (req_sweep_angle),
      .out_valid    (link_valid[0]),
      .out_ready    (link_ready[0]),
      .out_x        (link_x[0]),
      .out_y        (link_y[0]),
      .out_z        (link_z[0]),
      .out_start    (link_start[0]),
      .out_sweep    (link_sweep[0]),
      .out_flags    (link_flags[0])
   );

   // one cordic cell per angle bit
   for (genvar g = 0; g < ANGLE_BITS; g++) begin : g_cell
      ashit_cell #(
         .ANGLE_BITS (ANGLE_BITS),
         .LANE_BITS  (LANE_BITS),
         .STAGE      (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[g]),
         .in_ready  (link_ready[g]),
         .in_x      (link_x[g]),
         .in_y      (link_y[g]),
         .in_z      (link_z[g]),
         .in_start  (link_start[g]),
         .in_sweep  (link_sweep[g]),
         .in_flags  (link_flags[g]),
         .out_valid (link_valid[g+1]),
         .out_ready (link_ready[g+1]),
         .out_x     (link_x[g+1]),
         .out_y     (link_y[g+1]),
         .out_z     (link_z[g+1]),
         .out_start (link_start[g+1]),
         .out_sweep (link_sweep[g+1]),
         .out_flags (link_flags[g+1])
      );
   end

   ashit_back #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (link_valid[ANGLE_BITS]),
      .in_ready    (link_ready[ANGLE_BITS]),
      .in_z        (link_z[ANGLE_BITS]),
      .in_start    (link_start[ANGLE_BITS]),
      .in_sweep    (link_sweep[ANGLE_BITS]),
      .in_flags    (link_flags[ANGLE_BITS]),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_hit     (rsp_hit),
      .out_in_band (rsp_in_band),
      .out_bearing (rsp_bearing)
   );

`ifndef SYNTHESIS
   // a hit is only possible inside the radius band
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_hit || rsp_in_band))
      else $error("hit reported outside the radius band");

   // the last cell keeps its item while the back end is full
   assert property (@(posedge clock) disable iff (reset)
      (link_valid[ANGLE_BITS] && !link_ready[ANGLE_BITS]) |=> link_valid[ANGLE_BITS])
      else $error("item dropped at the end of the cordic chain");

   // no result comes out right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

/* tb/annular_sector_hit_test_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annular_sector_hit_test_tb
// Self-checking bench for the annular sector hit test. A stimulus table covers
// the centre point, the radius limits and the sweep corners first. Random
// points follow under several display centres, with idle gaps on both ports.
// Every result is checked against a known row or a cordic and band predictor.
// ----------------------------------------------------------------------------
module annular_sector_hit_test_tb;
   import ashit_pkg::*;

   localparam int CB = COORD_BITS_DEFAULT;
   localparam int AB = ANGLE_BITS_DEFAULT;
   localparam int COORD_MAX = (1 << CB) - 1;
   localparam int LATENCY = AB + 4;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES = 7;
   localparam int PHASE_ITEMS = 220;
   localparam int DIRECTED_ROWS = 17;
   localparam logic [AB:0] FULL_TURN = {1'b1, {AB{1'b0}}};
   localparam logic [AB-1:0] HALF_TURN = {1'b1, {(AB-1){1'b0}}};

   // atan(2^-i) as a fraction of a full turn, scaled by 2^32
   localparam int unsigned ATAN_FRAC [16] = '{
      536870912, 316933406, 167458907, 85004756,
      42667331,  21354465,  10679838,  5340245,
      2670163,   1335087,   667544,    333772,
      166886,    83443,     41722,     20861
   };

   typedef struct packed {
      logic [CB-1:0] point_x;
      logic [CB-1:0] point_y;
      logic [CB-1:0] inner_radius;
      logic [CB-1:0] outer_radius;
      logic [AB-1:0] start_angle;
      logic [AB:0]   sweep_angle;
   } touch_query_type;

   typedef struct packed {
      logic          hit;
      logic          in_band;
      logic [AB-1:0] bearing;
   } hit_result_type;

   typedef struct packed {
      touch_query_type query;
      logic            known;
      hit_result_type  result;
   } directed_row_type;

   // rows with known = 1 carry a result read straight off the geometry,
   // the rest go through the predictor; display centre is at reset (0, 0)
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      // point at centre, zero band, full turn
      '{'{10'd0, 10'd0, 10'd0, 10'd0, 16'h0000, 17'h10000}, 1'b1, '{1'b1, 1'b1, 16'h8000}},
      // point at centre, band excludes zero distance
      '{'{10'd0, 10'd0, 10'd1, 10'd5, 16'h0000, 17'h10000}, 1'b1, '{1'b0, 1'b0, 16'h8000}},
      // zero sweep never hits
      '{'{10'd0, 10'd0, 10'd0, 10'd0, 16'h0000, 17'h00000}, 1'b1, '{1'b0, 1'b1, 16'h8000}},
      // sweep with every bit set counts as a full turn
      '{'{10'd0, 10'd5, 10'd0, 10'd1023, 16'h0000, 17'h1FFFF}, 1'b1, '{1'b1, 1'b1, 16'h8000}},
      // straight down at the largest radius, one-step wedge on the bearing
      '{'{10'd0, 10'd1023, 10'd1023, 10'd1023, 16'h8000, 17'h00001}, 1'b1,
        '{1'b1, 1'b1, 16'h8000}},
      // wedge starts one step past the bearing and stops one short of it
      '{'{10'd0, 10'd1023, 10'd1023, 10'd1023, 16'h8001, 17'h0FFFF}, 1'b1,
        '{1'b0, 1'b1, 16'h8000}},
      '{'{10'd0, 10'd1023, 10'd1023, 10'd1023, 16'h7FFF, 17'h00002}, 1'b1,
        '{1'b1, 1'b1, 16'h8000}},
      // inner above outer gives an empty band
      '{'{10'd0, 10'd5, 10'd6, 10'd4, 16'h0000, 17'h10000}, 1'b1, '{1'b0, 1'b0, 16'h8000}},
      // just outside the outer radius
      '{'{10'd0, 10'd6, 10'd0, 10'd5, 16'h0000, 17'h10000}, 1'b1, '{1'b0, 1'b0, 16'h8000}},
      '{'{10'd5, 10'd0, 10'd0, 10'd5, 16'h0000, 17'h10000}, 1'b0, '0},
      '{'{10'd1023, 10'd0, 10'd1023, 10'd1023, 16'h3FF0, 17'h00020}, 1'b0, '0},
      '{'{10'd1023, 10'd1023, 10'd0, 10'd1023, 16'h0000, 17'h0FFFF}, 1'b0, '0},
      '{'{10'd1023, 10'd1023, 10'd1023, 10'd1023, 16'hFFFF, 17'h10000}, 1'b0, '0},
      '{'{10'd1, 10'd1, 10'd1, 10'd1, 16'h6000, 17'h04000}, 1'b0, '0},
      '{'{10'd700, 10'd300, 10'd0, 10'd1023, 16'hAAAA, 17'h15555}, 1'b0, '0},
      '{'{10'd341, 10'd682, 10'd0, 10'd1023, 16'h5555, 17'h0AAAA}, 1'b0, '0},
      '{'{10'd1023, 10'd1, 10'd0, 10'd1023, 16'h0000, 17'h10000}, 1'b0, '0}
   };

   logic            clock = 1'b0;
   logic            reset;
   logic            csr_wr_en;
   logic [0:0]      csr_index;
   logic [CB-1:0]   csr_wr_data;
   logic            req_valid;
   logic            req_ready;
   logic [CB-1:0]   req_point_x;
   logic [CB-1:0]   req_point_y;
   logic [CB-1:0]   req_inner_radius;
   logic [CB-1:0]   req_outer_radius;
   logic [AB-1:0]   req_start_angle;
   logic [AB:0]     req_sweep_angle;
   logic            rsp_valid;
   logic            rsp_ready;
   logic            rsp_hit;
   logic            rsp_in_band;
   logic [AB-1:0]   rsp_bearing;

   // centre registers as the predictor sees them
   int cfg_cx = 0;
   int cfg_cy = 0;

   hit_result_type pending_hits [$];
   int  mismatch_count = 0;
   int  items_sent = 0;
   int  results_seen = 0;
   int  hits_seen = 0;
   int  in_band_seen = 0;
   int  centre_settings = 1;
   int  cycle_count = 0;
   bit  send_quiet = 1'b0;
   bit  sink_quiet = 1'b0;

   annular_sector_hit_test dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_inner_radius (req_inner_radius),
      .req_outer_radius (req_outer_radius),
      .req_start_angle  (req_start_angle),
      .req_sweep_angle  (req_sweep_angle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_in_band      (rsp_in_band),
      .rsp_bearing      (rsp_bearing)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // bearing by cordic vectoring, up is zero and clockwise is positive
   function automatic logic [AB-1:0] cordic_bearing(input int dx, input int dy);
      longint      vx;
      longint      vy;
      longint      sx;
      longint      sy;
      logic [31:0] acc;
      logic [31:0] step;
      int          i;
      if (dx == 0 && dy == 0)
         return HALF_TURN;
      vx = longint'(-dy) <<< AB;
      vy = longint'(dx) <<< AB;
      acc = '0;
      // left half plane: rotate by half a turn first
      if (vx < 0) begin
         vx = -vx;
         vy = -vy;
         acc = 32'(HALF_TURN);
      end
      for (i = 0; i < AB; i++) begin
         sx = vx >>> i;
         sy = vy >>> i;
         step = (ATAN_FRAC[i] + (32'd1 << (31 - AB))) >> (32 - AB);
         if (vy > 0) begin
            vx = vx + sy;
            vy = vy - sx;
            acc = acc + step;
         end else if (vy < 0) begin
            vx = vx - sy;
            vy = vy + sx;
            acc = acc - step;
         end
      end
      return acc[AB-1:0];
   endfunction

   // full result of one query under the current centre
   function automatic hit_result_type predict_hit(input touch_query_type q);
      int             dx;
      int             dy;
      longint         d2;
      longint         r_in;
      longint         r_out;
      logic [AB-1:0]  rel;
      hit_result_type r;
      dx = int'(q.point_x) - cfg_cx;
      dy = int'(q.point_y) - cfg_cy;
      d2 = longint'(dx) * dx + longint'(dy) * dy;
      r_in = longint'(q.inner_radius);
      r_out = longint'(q.outer_radius);
      r.in_band = !(d2 < r_in * r_in || d2 > r_out * r_out);
      r.bearing = cordic_bearing(dx, dy);
      rel = r.bearing - q.start_angle;
      if (!r.in_band || q.sweep_angle == '0)
         r.hit = 1'b0;
      else if (q.sweep_angle >= FULL_TURN)
         r.hit = 1'b1;
      else
         r.hit = {1'b0, rel} < q.sweep_angle;
      return r;
   endfunction

   function automatic int clip_coord(input int v);
      if (v < 0)
         return 0;
      if (v > COORD_MAX)
         return COORD_MAX;
      return v;
   endfunction

   // one request transfer, preceded by a random gap
   task automatic send_query(input touch_query_type q, input logic known,
                             input hit_result_type given);
      int gap;
      if ($urandom_range(0, 39) == 0)
         send_quiet = !send_quiet;
      gap = send_quiet ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_point_x <= q.point_x;
      req_point_y <= q.point_y;
      req_inner_radius <= q.inner_radius;
      req_outer_radius <= q.outer_radius;
      req_start_angle <= q.start_angle;
      req_sweep_angle <= q.sweep_angle;
      do @(posedge clock); while (!req_ready);
      pending_hits.push_back(known ? given : predict_hit(q));
      items_sent++;
   endtask

   // stop sending until every result is back and the pipeline is empty
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_hits.size() != 0);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   // both centre registers on consecutive cycles
   task automatic set_centre(input int cx, input int cy);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_CENTRE_X;
      csr_wr_data <= CB'(cx);
      @(posedge clock);
      csr_index <= CSR_CENTRE_Y;
      csr_wr_data <= CB'(cy);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_cx = cx;
      cfg_cy = cy;
      centre_settings++;
   endtask

   // stimulus
   initial begin : stimulus
      touch_query_type q;
      int           phase;
      int           n;
      int           mode;
      int           span;
      int           dx;
      int           dy;
      int           px;
      int           py;
      int           rd;
      int           ri;
      int           ro;
      longint       d2;
      logic [AB-1:0] bear;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_CENTRE_X;
      csr_wr_data <= '0;
      req_valid <= 1'b0;
      req_point_x <= '0;
      req_point_y <= '0;
      req_inner_radius <= '0;
      req_outer_radius <= '0;
      req_start_angle <= '0;
      req_sweep_angle <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table at the reset centre
      for (n = 0; n < DIRECTED_ROWS; n++)
         send_query(DIRECTED[n].query, DIRECTED[n].known, DIRECTED[n].result);
      hold_until_drained();

      // random phases, each under its own centre
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: set_centre(512, 512);
            1: set_centre(0, 0);
            2: set_centre(COORD_MAX, COORD_MAX);
            3: set_centre(COORD_MAX, 0);
            4: set_centre(0, COORD_MAX);
            default: set_centre($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
         endcase
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // point placement relative to the centre
            mode = $urandom_range(0, 9);
            dx = 0;
            dy = 0;
            if (mode == 0) begin
               dx = $urandom_range(0, COORD_MAX) - cfg_cx;
               dy = $urandom_range(0, COORD_MAX) - cfg_cy;
            end else if (mode == 2) begin
               span = $urandom_range(1, COORD_MAX);
               if ($urandom_range(0, 1))
                  span = -span;
               if ($urandom_range(0, 1))
                  dx = span;
               else
                  dy = span;
            end else if (mode != 1) begin
               span = $urandom_range(0, 1) ? 24 : COORD_MAX;
               dx = int'($urandom_range(0, 2 * span)) - span;
               dy = int'($urandom_range(0, 2 * span)) - span;
            end
            px = clip_coord(cfg_cx + dx);
            py = clip_coord(cfg_cy + dy);
            d2 = longint'(px - cfg_cx) * (px - cfg_cx) + longint'(py - cfg_cy) * (py - cfg_cy);

            // band around the true distance, or anything at all
            rd = clip_coord(int'($floor($sqrt(real'(d2)))));
            if ($urandom_range(0, 4) == 0) begin
               ri = $urandom_range(0, COORD_MAX);
               ro = $urandom_range(0, COORD_MAX);
            end else begin
               ri = ($urandom_range(0, 5) == 0) ? rd + 1 : rd - int'($urandom_range(0, 40));
               ro = ($urandom_range(0, 5) == 0) ? rd - 1 : rd + int'($urandom_range(0, 40));
               if ($urandom_range(0, 9) == 0) begin
                  ri = rd;
                  ro = rd;
               end
            end

            // wedge: zero, full turn and beyond, random, or tight on the bearing
            bear = cordic_bearing(px - cfg_cx, py - cfg_cy);
            q.point_x = CB'(px);
            q.point_y = CB'(py);
            q.inner_radius = CB'(clip_coord(ri));
            q.outer_radius = CB'(clip_coord(ro));
            q.start_angle = AB'($urandom());
            mode = $urandom_range(0, 9);
            if (mode == 0)
               q.sweep_angle = '0;
            else if (mode == 1)
               q.sweep_angle = ($urandom_range(0, 1)) ? FULL_TURN
                                                      : (AB + 1)'($urandom_range(65536, 131071));
            else if (mode < 5)
               q.sweep_angle = (AB + 1)'($urandom_range(0, 131071));
            else begin
               q.start_angle = bear - AB'($urandom_range(0, 3)) + AB'($urandom_range(0, 1));
               q.sweep_angle = ($urandom_range(0, 2) == 0)
                               ? (AB + 1)'($urandom_range(1, 65535))
                               : (AB + 1)'($urandom_range(0, 4));
            end
            send_query(q, 1'b0, '0);

            // one mid-phase pause with the pipeline fully drained
            if (phase == 3 && n == PHASE_ITEMS / 2)
               hold_until_drained();
         end
         hold_until_drained();
      end

      $display("checked %0d of %0d queries under %0d centre settings: %0d in band, %0d hits",
               results_seen, items_sent, centre_settings, in_band_seen, hits_seen);
      $display("sweeps covered zero, full turn, beyond a full turn and bearing edges");
      if (mismatch_count == 0)
         $display("PASS annular_sector_hit_test");
      else
         $display("FAIL annular_sector_hit_test");
      $finish;
   end

   // result side: random stall before each transfer, with quiet stretches
   initial begin : result_sink
      int stall;
      forever begin
         if ($urandom_range(0, 49) == 0)
            sink_quiet = !sink_quiet;
         stall = sink_quiet ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // compare each result transfer with the oldest pending prediction
   always @(posedge clock) begin : result_check
      hit_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_hits.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: hit %0b in_band %0b bearing %h",
                        rsp_hit, rsp_in_band, rsp_bearing);
         end else begin
            want = pending_hits.pop_front();
            if (rsp_hit !== want.hit || rsp_in_band !== want.in_band ||
                rsp_bearing !== want.bearing) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected hit %0b in_band %0b bearing %h, got %0b %0b %h",
                           want.hit, want.in_band, want.bearing,
                           rsp_hit, rsp_in_band, rsp_bearing);
            end
            if (rsp_hit === 1'b1)
               hits_seen++;
            if (rsp_in_band === 1'b1)
               in_band_seen++;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", pending_hits.size());
         $display("FAIL annular_sector_hit_test");
         $finish;
      end
   end

endmodule
